>>> hw/rtl/islw_pkg.sv
// islw_pkg: widths, register codes, control structs and helpers for the
// integer scale letterbox writer; no dependencies
package islw_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int MAX_SCALE = 8;

    localparam int REG_W     = 13;                      // configuration register width
    localparam int CNT_W     = $clog2(MAX_DIM);         // source position counters
    localparam int SCALE_W   = $clog2(MAX_SCALE + 1);   // scale factor, 0 = crop
    localparam int POS_W     = CNT_W + SCALE_W;         // window row / column of a block
    localparam int CMP_W     = REG_W + 1;
    localparam int ACC_W     = REG_W + SCALE_W;
    localparam int ADDR_W    = 24;
    localparam int PIX_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_WIDTH  = 2'd0,
        CFG_WINDOW_HEIGHT = 2'd1,
        CFG_SOURCE_WIDTH  = 2'd2,
        CFG_SOURCE_HEIGHT = 2'd3
    } islw_cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic accept;       // take the item, advance the position counters
        logic derive_step;  // one trial scale per cycle
        logic offs_load;    // latch scale and offsets
        logic pos_calc;     // block origin or crop position
        logic base_calc;    // first frame-store address
        logic emit_load;    // move one write into the output register
    } islw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic derive_done;
        logic emit_none;
        logic emit_final;
        logic out_free;
    } islw_stat_t;

    // zero counts as one, anything above the largest dimension saturates
    function automatic logic [REG_W-1:0] islw_clamp(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        if (v == '0)
            r = REG_W'(1);
        else if (CMP_W'(v) > CMP_W'(MAX_DIM))
            r = REG_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

>>> hw/rtl/islw_pix_if.sv
// islw_pix_if: source pixel channel, valid/ready with payload
// depends on islw_pkg
interface islw_pix_if;
    import islw_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

>>> hw/rtl/islw_wr_if.sv
// islw_wr_if: frame-store write channel, valid/ready with payload
// depends on islw_pkg
interface islw_wr_if;
    import islw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_pixel;
    logic              run_last;

    modport source (output valid, output write_address, output write_pixel,
                    output run_last, input ready);
    modport sink   (input valid, input write_address, input write_pixel,
                    input run_last, output ready);
endinterface

>>> hw/rtl/islw_datapath.sv
// islw_datapath: registers, position counters, scale search, address
// generation and output register; depends on islw_pkg
module islw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [islw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [islw_pkg::REG_W-1:0]     cfg_data,
    input  logic [islw_pkg::PIX_W-1:0]     in_pixel,
    input  logic                          in_frame_start,
    input  islw_pkg::islw_cmd_t           cmd,
    output islw_pkg::islw_stat_t          stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [islw_pkg::ADDR_W-1:0]    out_addr,
    output logic [islw_pkg::PIX_W-1:0]     out_pixel,
    output logic                          out_last
);
    import islw_pkg::*;

    logic [REG_W-1:0]   ww_reg, wh_reg, sw_reg, sh_reg;
    logic [REG_W-1:0]   ww_c, wh_c, sw_c, sh_c;

    logic [CNT_W-1:0]   col_reg, row_reg, cur_col_reg, cur_row_reg;
    logic [CNT_W-1:0]   col_next, row_next, pos_col, pos_row;
    logic [CNT_W:0]     col_plus, row_plus;

    logic [SCALE_W-1:0] scale_reg, k_reg, s_work_reg;
    logic [ACC_W-1:0]   accw_reg, acch_reg;
    logic               fit;
    logic [REG_W-1:0]   off_col_reg, off_row_reg, off_col_new, off_row_new;
    logic [ACC_W-1:0]   prod_w, prod_h, diff_w, diff_h;
    logic signed [REG_W:0] crop_dw, crop_dh, half_dw, half_dh;

    logic [POS_W-1:0]   r0_reg, c0_reg, r0_new, c0_new;
    logic               vis_reg, vis_new;
    logic signed [POS_W:0] wx, wy;

    logic [POS_W+REG_W-1:0] base_sum;
    logic [ADDR_W-1:0]  addr_reg, row_start_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [SCALE_W-1:0] a_reg, b_reg, n_run, n_last;
    logic               b_end, final_w;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ww_reg <= REG_W'(640);
            wh_reg <= REG_W'(480);
            sw_reg <= REG_W'(320);
            sh_reg <= REG_W'(240);
        end
        else if (cfg_we)
        begin
            unique case (islw_cfg_idx_t'(cfg_index))
                CFG_WINDOW_WIDTH:  ww_reg <= cfg_data;
                CFG_WINDOW_HEIGHT: wh_reg <= cfg_data;
                CFG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                CFG_SOURCE_HEIGHT: sh_reg <= cfg_data;
            endcase
        end
    end

    assign ww_c = islw_clamp(ww_reg);
    assign wh_c = islw_clamp(wh_reg);
    assign sw_c = islw_clamp(sw_reg);
    assign sh_c = islw_clamp(sh_reg);

    // position of this item and of the next one
    assign pos_col  = in_frame_start ? '0 : col_reg;
    assign pos_row  = in_frame_start ? '0 : row_reg;
    assign col_plus = {1'b0, pos_col} + (CNT_W+1)'(1);

    always_comb
    begin
        if (CMP_W'(col_plus) >= CMP_W'(sw_c))
        begin
            col_next = '0;
            row_plus = {1'b0, pos_row} + (CNT_W+1)'(1);
        end
        else
        begin
            col_next = col_plus[CNT_W-1:0];
            row_plus = {1'b0, pos_row};
        end
        if (CMP_W'(row_plus) >= CMP_W'(sh_c))
            row_next = '0;
        else
            row_next = row_plus[CNT_W-1:0];
    end

    // scale search: largest k with source*k inside the window
    assign fit = (accw_reg <= ACC_W'(ww_c)) && (acch_reg <= ACC_W'(wh_c));

    // offsets from the chosen scale
    assign prod_w  = ACC_W'(sw_c) * ACC_W'(s_work_reg);
    assign prod_h  = ACC_W'(sh_c) * ACC_W'(s_work_reg);
    assign diff_w  = ACC_W'(ww_c) - prod_w;
    assign diff_h  = ACC_W'(wh_c) - prod_h;
    assign crop_dw = $signed({1'b0, sw_c}) - $signed({1'b0, ww_c});
    assign crop_dh = $signed({1'b0, sh_c}) - $signed({1'b0, wh_c});
    // halve, rounding toward zero
    assign half_dw = (crop_dw + $signed({{REG_W{1'b0}}, crop_dw[REG_W]})) >>> 1;
    assign half_dh = (crop_dh + $signed({{REG_W{1'b0}}, crop_dh[REG_W]})) >>> 1;

    always_comb
    begin
        if (s_work_reg != '0)
        begin
            off_col_new = REG_W'(diff_w[ACC_W-1:1]);
            off_row_new = REG_W'(diff_h[ACC_W-1:1]);
        end
        else
        begin
            off_col_new = half_dw[REG_W-1:0];
            off_row_new = half_dh[REG_W-1:0];
        end
    end

    // block origin in scale mode, window position in crop mode
    assign wx = $signed({{(POS_W+1-CNT_W){1'b0}}, cur_col_reg})
              - $signed({{(POS_W+1-REG_W){off_col_reg[REG_W-1]}}, off_col_reg});
    assign wy = $signed({{(POS_W+1-CNT_W){1'b0}}, cur_row_reg})
              - $signed({{(POS_W+1-REG_W){off_row_reg[REG_W-1]}}, off_row_reg});

    always_comb
    begin
        if (scale_reg != '0)
        begin
            r0_new  = POS_W'(off_row_reg) + POS_W'(cur_row_reg) * POS_W'(scale_reg);
            c0_new  = POS_W'(off_col_reg) + POS_W'(cur_col_reg) * POS_W'(scale_reg);
            vis_new = 1'b1;
        end
        else
        begin
            r0_new  = wy[POS_W-1:0];
            c0_new  = wx[POS_W-1:0];
            vis_new = !wx[POS_W] && !wy[POS_W]
                   && (wx[POS_W-1:0] < POS_W'(ww_c)) && (wy[POS_W-1:0] < POS_W'(wh_c));
        end
    end

    assign base_sum = (POS_W+REG_W)'(r0_reg) * (POS_W+REG_W)'(ww_c)
                    + (POS_W+REG_W)'(c0_reg);

    // run of writes: n by n block, or a single write in crop mode
    assign n_run   = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    assign n_last  = n_run - SCALE_W'(1);
    assign b_end   = (b_reg == n_last);
    assign final_w = b_end && (a_reg == n_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            scale_reg   <= '0;
            off_col_reg <= '0;
            off_row_reg <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cmd.offs_load)
            begin
                scale_reg   <= s_work_reg;
                off_col_reg <= off_col_new;
                off_row_reg <= off_row_new;
            end
            if (cmd.emit_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg     <= in_pixel;
            cur_col_reg <= pos_col;
            cur_row_reg <= pos_row;
            k_reg       <= SCALE_W'(1);
            s_work_reg  <= '0;
            accw_reg    <= ACC_W'(sw_c);
            acch_reg    <= ACC_W'(sh_c);
        end
        if (cmd.derive_step && fit)
        begin
            s_work_reg <= k_reg;
            k_reg      <= k_reg + SCALE_W'(1);
            accw_reg   <= accw_reg + ACC_W'(sw_c);
            acch_reg   <= acch_reg + ACC_W'(sh_c);
        end
        if (cmd.pos_calc)
        begin
            r0_reg  <= r0_new;
            c0_reg  <= c0_new;
            vis_reg <= vis_new;
        end
        if (cmd.base_calc)
        begin
            addr_reg      <= base_sum[ADDR_W-1:0];
            row_start_reg <= base_sum[ADDR_W-1:0];
            a_reg         <= '0;
            b_reg         <= '0;
        end
        if (cmd.emit_load)
        begin
            out_addr  <= addr_reg;
            out_pixel <= pix_reg;
            out_last  <= final_w;
            if (b_end)
            begin
                b_reg         <= '0;
                a_reg         <= a_reg + SCALE_W'(1);
                row_start_reg <= row_start_reg + ADDR_W'(ww_c);
                addr_reg      <= row_start_reg + ADDR_W'(ww_c);
            end
            else
            begin
                b_reg    <= b_reg + SCALE_W'(1);
                addr_reg <= addr_reg + ADDR_W'(1);
            end
        end
    end

    assign stat.derive_done = !fit || (k_reg == SCALE_W'(MAX_SCALE));
    assign stat.emit_none   = !vis_reg;
    assign stat.emit_final  = final_w;
    assign stat.out_free    = !out_valid || out_ready;

endmodule

>>> hw/rtl/islw_ctrl.sv
// islw_ctrl: sequencer for one source item at a time
// depends on islw_pkg
module islw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_frame_start,
    output logic                 in_ready,
    input  islw_pkg::islw_stat_t stat,
    output islw_pkg::islw_cmd_t  cmd
);
    import islw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DERIVE,
        ST_OFFS,
        ST_POS,
        ST_BASE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                        state_reg <= in_frame_start ? ST_DERIVE : ST_POS;
                ST_DERIVE:
                    if (stat.derive_done)
                        state_reg <= ST_OFFS;
                ST_OFFS:
                    state_reg <= ST_POS;
                ST_POS:
                    state_reg <= ST_BASE;
                ST_BASE:
                    state_reg <= stat.emit_none ? ST_IDLE : ST_EMIT;
                ST_EMIT:
                    if (stat.out_free && stat.emit_final)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.accept      = accept;
        cmd.derive_step = (state_reg == ST_DERIVE);
        cmd.offs_load   = (state_reg == ST_OFFS);
        cmd.pos_calc    = (state_reg == ST_POS);
        cmd.base_calc   = (state_reg == ST_BASE);
        cmd.emit_load   = (state_reg == ST_EMIT) && stat.out_free;
    end

endmodule

>>> hw/rtl/integer_scale_letterbox_writer_unit.sv
// an accepted item passes the position and base states before its first write is loaded;
// a frame-start item first runs the scale search and latches scale and offsets
// each source pixel gives an n by n run of writes in scale mode (n = scale, up to 8), one
// write in crop mode and none when the pixel falls outside the window; the write
// sequencer issues one write per cycle while the write side takes them
// reset: asynchronous active-low rst_n; registers return to 640x480 / 320x240,
// counters, scale and offsets clear to zero (crop mode with no offset)
module integer_scale_letterbox_writer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [islw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [islw_pkg::REG_W-1:0]     cfg_data,
    islw_pix_if.sink                       pix_in,
    islw_wr_if.source                      wr_out
);
    import islw_pkg::*;

    islw_cmd_t  cmd;
    islw_stat_t stat;

    // sequencer: idle accept, optional scale search, position, base, write run
    islw_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pix_in.valid),
        .in_frame_start (pix_in.frame_start),
        .in_ready       (pix_in.ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    // datapath holds the registers, counters and the output register, so the
    // next item can be taken while the last write of this one is still pending
    islw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_pixel       (pix_in.pixel_value),
        .in_frame_start (pix_in.frame_start),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (wr_out.valid),
        .out_ready      (wr_out.ready),
        .out_addr       (wr_out.write_address),
        .out_pixel      (wr_out.write_pixel),
        .out_last       (wr_out.run_last)
    );

endmodule

>>> hw/rtl/islw_checker.sv
// islw_checker: port-level assertions for the letterbox writer
// depends on islw_pkg; bound to integer_scale_letterbox_writer_unit
module islw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [islw_pkg::ADDR_W-1:0] out_addr,
    input logic                        out_last
);
    import islw_pkg::*;

    // a stalled write stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("write dropped while stalled");

    // a stalled write keeps its address
    a_addr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_addr))
        else $error("write address changed while stalled");

    // one item at a time: no new item while a run is unfinished
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready during an unfinished run");

    // an accepted item always occupies the sequencer for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after an accept");

endmodule

bind integer_scale_letterbox_writer_unit islw_checker u_islw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (wr_out.valid),
    .out_ready (wr_out.ready),
    .out_addr  (wr_out.write_address),
    .out_last  (wr_out.run_last)
);

>>> tb/sv/integer_scale_letterbox_writer_unit_checker.sv
// integer_scale_letterbox_writer_unit_checker: watches the register, pixel and write ports,
// predicts the frame-store writes of every accepted pixel and counts mismatches
// depends on islw_pkg, islw_pix_if and islw_wr_if
module integer_scale_letterbox_writer_unit_checker
    import islw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    islw_pix_if                  pix,
    islw_wr_if                   wr,
    input  logic                 run_done,
    output int                   mismatches,
    output int                   writes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  pixel;
        logic              last;
    } store_write_t;

    store_write_t writes_due[$];

    logic [REG_W-1:0]        win_w, win_h, src_w, src_h;
    logic [CNT_W-1:0]        col, row;
    logic [SCALE_W-1:0]      scale;
    logic signed [REG_W-1:0] offs_col, offs_row;
    bit                      leftovers_checked;

    task automatic note_mismatch(input string msg);
        mismatches++;
        // keep the log short when the block is badly off
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
    endtask

    // zero reads as one, anything past the largest dimension saturates
    function automatic int dim_of(input logic [REG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void latch_geometry();
        int ww, wh, sw, sh, s;
        ww = dim_of(win_w);
        wh = dim_of(win_h);
        sw = dim_of(src_w);
        sh = dim_of(src_h);
        s = (ww / sw < wh / sh) ? ww / sw : wh / sh;
        if (s > MAX_SCALE)
            s = MAX_SCALE;
        scale = SCALE_W'(s);
        if (s >= 1)
        begin
            offs_col = REG_W'((ww - sw * s) / 2);
            offs_row = REG_W'((wh - sh * s) / 2);
        end
        else
        begin
            offs_col = REG_W'((sw - ww) / 2);
            offs_row = REG_W'((sh - wh) / 2);
        end
    endfunction

    task automatic predict_store_writes(input logic [PIX_W-1:0] pixel, input logic first);
        int ww, wh, sw, sh, s, r0, c0, wx, wy, a, b, next_col, next_row;
        logic [31:0]  addr;
        store_write_t w;
        ww = dim_of(win_w);
        wh = dim_of(win_h);
        sw = dim_of(src_w);
        sh = dim_of(src_h);
        if (first)
        begin
            col = '0;
            row = '0;
            latch_geometry();
        end
        s = int'(scale);
        if (s >= 1)
        begin
            r0 = int'(offs_row) + int'(row) * s;
            c0 = int'(offs_col) + int'(col) * s;
            for (a = 0; a < s; a++)
            begin
                for (b = 0; b < s; b++)
                begin
                    addr      = 32'((r0 + a) * ww + c0 + b);
                    w.address = addr[ADDR_W-1:0];
                    w.pixel   = pixel;
                    w.last    = (a == s - 1) && (b == s - 1);
                    writes_due.push_back(w);
                end
            end
        end
        else
        begin
            wx = int'(col) - int'(offs_col);
            wy = int'(row) - int'(offs_row);
            if (wx >= 0 && wy >= 0 && wx < ww && wy < wh)
            begin
                addr      = 32'(wy * ww + wx);
                w.address = addr[ADDR_W-1:0];
                w.pixel   = pixel;
                w.last    = 1'b1;
                writes_due.push_back(w);
            end
        end
        next_col = int'(col) + 1;
        next_row = int'(row);
        if (next_col >= sw)
        begin
            next_col = 0;
            next_row++;
            if (next_row >= sh)
                next_row = 0;
        end
        if (next_row >= sh)
            next_row = 0;
        col = CNT_W'(next_col);
        row = CNT_W'(next_row);
    endtask

    task automatic check_store_write();
        store_write_t want;
        if (writes_due.size() == 0)
        begin
            note_mismatch($sformatf("write to %h with none expected", wr.write_address));
        end
        else
        begin
            want = writes_due.pop_front();
            if (wr.write_address !== want.address)
                note_mismatch($sformatf("write_address %h, expected %h",
                                        wr.write_address, want.address));
            if (wr.write_pixel !== want.pixel)
                note_mismatch($sformatf("write_pixel %h at %h, expected %h",
                                        wr.write_pixel, want.address, want.pixel));
            if (wr.run_last !== want.last)
                note_mismatch($sformatf("run_last %b at %h, expected %b",
                                        wr.run_last, want.address, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w    = 13'd640;
            win_h    = 13'd480;
            src_w    = 13'd320;
            src_h    = 13'd240;
            col      = '0;
            row      = '0;
            scale    = '0;
            offs_col = '0;
            offs_row = '0;
            writes_due.delete();
        end
        else
        begin
            // a write in this edge belongs to an earlier pixel, so match before predicting
            if (wr.valid && wr.ready)
                check_store_write();
            if (pix.valid && pix.ready)
                predict_store_writes(pix.pixel_value, pix.frame_start);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_WIDTH:  win_w = cfg_data;
                    CFG_WINDOW_HEIGHT: win_h = cfg_data;
                    CFG_SOURCE_WIDTH:  src_w = cfg_data;
                    CFG_SOURCE_HEIGHT: src_h = cfg_data;
                    default:           ;
                endcase
            end
            if (run_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (writes_due.size() != 0)
                    note_mismatch($sformatf("%0d writes never arrived, first to %h",
                                            writes_due.size(), writes_due[0].address));
            end
        end
        writes_outstanding = writes_due.size();
    end

endmodule

>>> tb/sv/integer_scale_letterbox_writer_unit_test.sv
// integer_scale_letterbox_writer_unit_test: clock, reset, register writes, pixel stimulus
// and write-side back-pressure for the letterbox writer, with the checker alongside
// depends on islw_pkg, islw_pix_if, islw_wr_if and the checker module
module integer_scale_letterbox_writer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import islw_pkg::*;

    localparam int SETTLE_CYCLES  = 24;    // longer than an item's latency, also on a frame start
    localparam int WATCHDOG_LIMIT = 2000;  // far longer than the longest quiet stretch
    localparam int RANDOM_ITEMS   = 90;
    localparam int TALL_ROWS      = 264;   // rows past 255 push the address over 24 bits

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    islw_cfg_idx_t       cfg_index;
    logic [REG_W-1:0]    cfg_data;
    logic                run_done;
    int                  mismatches;
    int                  writes_outstanding;
    bit                  feed_burst;
    bit                  sink_burst;
    int                  stall_left;
    int                  idle_cycles = 0;
    int                  random_items;

    islw_pix_if pix ();
    islw_wr_if  wr ();

    integer_scale_letterbox_writer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix),
        .wr_out    (wr)
    );

    integer_scale_letterbox_writer_unit_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .pix                (pix),
        .wr                 (wr),
        .run_done           (run_done),
        .mismatches         (mismatches),
        .writes_outstanding (writes_outstanding)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // register value biased towards the clamp edges
    function automatic logic [REG_W-1:0] any_dim();
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4095;
            3:       return 13'd4096;
            4:       return 13'd4097;
            5:       return 13'd8191;
            default: return REG_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // write-side back-pressure, changed on the falling edge
    initial
    begin
        wr.ready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                wr.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                wr.ready = 1'b1;
                if (!sink_burst && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // no item moving on either side for too long means the block has hung
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (wr.valid && wr.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // register write, one cycle of write enable
    task automatic write_reg(input islw_cfg_idx_t idx, input logic [REG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic write_geometry(input logic [REG_W-1:0] ww, input logic [REG_W-1:0] wh,
                                  input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh);
        write_reg(CFG_WINDOW_WIDTH, ww);
        write_reg(CFG_WINDOW_HEIGHT, wh);
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
    endtask

    // one source pixel; valid stays high into the next item unless a gap is drawn
    task automatic send_pixel(input logic [PIX_W-1:0] value, input logic first);
        int gap;
        gap = feed_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid       = 1'b1;
        pix.pixel_value = value;
        pix.frame_start = first;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender holds off until every predicted write has landed
    task automatic drain_writes();
        pix.valid = 1'b0;
        while (writes_outstanding != 0)
            @(negedge clk);
    endtask

    // idle point for register writes: crop pixels that write nothing may still be in flight
    task automatic settle();
        drain_writes();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic choose_geometry();
        logic [REG_W-1:0] ww, wh, sw, sh;
        int               kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            // small frames, every scale from crop up to saturation
            sw = REG_W'($urandom_range(1, 6));
            sh = REG_W'($urandom_range(1, 6));
            ww = REG_W'($urandom_range(1, 56));
            wh = REG_W'($urandom_range(1, 56));
        end
        else if (kind <= 6)
        begin
            // centre crop with a good share of pixels landing in the window
            sw = REG_W'($urandom_range(3, 12));
            sh = REG_W'($urandom_range(3, 12));
            ww = REG_W'($urandom_range(1, int'(sw) - 1));
            wh = REG_W'($urandom_range(1, int'(sh) + 3));
        end
        else if (kind == 7)
        begin
            ww = any_dim();
            wh = any_dim();
            sw = any_dim();
            sh = any_dim();
        end
        else if (kind == 8)
        begin
            ww = REG_W'($urandom_range(0, 8191));
            wh = REG_W'($urandom_range(0, 8191));
            sw = REG_W'($urandom_range(0, 8191));
            sh = REG_W'($urandom_range(0, 8191));
        end
        else
        begin
            // wide window over a tiny source, scale saturates with large offsets
            ww = REG_W'($urandom_range(1024, 8191));
            wh = REG_W'($urandom_range(1024, 8191));
            sw = REG_W'($urandom_range(0, 4));
            sh = REG_W'($urandom_range(0, 4));
        end
        write_geometry(ww, wh, sw, sh);
    endtask

    initial
    begin
        int  run_len;
        int  k;
        bit  mid_frame;
        bit  restart;

        pix.valid       = 1'b0;
        pix.pixel_value = '0;
        pix.frame_start = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_WINDOW_WIDTH;
        cfg_data        = '0;
        run_done        = 1'b0;
        feed_burst      = 1'b0;
        sink_burst      = 1'b0;
        random_items    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // before any frame start: crop with no offset on the reset geometry
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        // frame start on the reset geometry: scale 2, no offsets
        send_pixel(32'hA5A5_A5A5, 1'b1);
        send_pixel(32'h5A5A_5A5A, 1'b0);

        // zero and out-of-range registers, crop with a negative row offset
        settle();
        write_geometry(13'd0, 13'd8191, 13'd8191, 13'd0);
        send_pixel($urandom(), 1'b1);
        send_pixel($urandom(), 1'b0);

        // scale saturates at the maximum; the source wraps back to the origin
        settle();
        write_geometry(13'd4096, 13'd4096, 13'd2, 13'd2);
        send_pixel($urandom(), 1'b1);
        send_pixel($urandom(), 1'b0);
        drain_writes();
        send_pixel($urandom(), 1'b0);
        send_pixel($urandom(), 1'b0);
        send_pixel($urandom(), 1'b0);

        // centre crop with pixels inside and outside the window, restarted mid-frame
        settle();
        write_geometry(13'd3, 13'd2, 13'd5, 13'd4);
        for (k = 0; k < 8; k++)
            send_pixel($urandom(), k == 0 || k == 5);

        // source width changed within the frame: latched crop stays, wrap follows the register
        settle();
        write_reg(CFG_SOURCE_WIDTH, 13'd2);
        for (k = 0; k < 3; k++)
            send_pixel($urandom(), 1'b0);

        // one-pixel-wide source at the largest scale, then the height opened up mid-frame
        // so the rows run far enough down for the address to wrap at 24 bits
        settle();
        write_geometry(13'd4096, 13'd4096, 13'd1, 13'd1);
        send_pixel($urandom(), 1'b1);
        settle();
        write_reg(CFG_SOURCE_HEIGHT, 13'd4096);
        feed_burst = ($urandom_range(0, 1) == 0);
        sink_burst = ($urandom_range(0, 1) == 0);
        for (k = 0; k < TALL_ROWS; k++)
            send_pixel($urandom(), 1'b0);

        // random phases: mostly whole frames, some register changes inside a frame
        // and stray frame starts
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            feed_burst = ($urandom_range(0, 5) == 0);
            sink_burst = ($urandom_range(0, 5) == 0);
            mid_frame  = ($urandom_range(0, 4) == 0);
            if (mid_frame)
            begin
                write_reg(islw_cfg_idx_t'($urandom_range(0, 3)),
                          REG_W'($urandom_range(1, 48)));
                if ($urandom_range(0, 1) == 0)
                    write_reg(islw_cfg_idx_t'($urandom_range(0, 3)), any_dim());
            end
            else
            begin
                choose_geometry();
            end
            run_len = $urandom_range(4, 30);
            for (k = 0; k < run_len; k++)
            begin
                restart = (!mid_frame && k == 0) || ($urandom_range(0, 29) == 0);
                send_pixel($urandom(), restart);
                random_items++;
                if ($urandom_range(0, 49) == 0)
                    drain_writes();
            end
        end

        // wait out the last writes, then let the checker look for leftovers
        settle();
        run_done = 1'b1;
        repeat (2) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
